>>> rtl/csq_pkg.sv
package csq_pkg;

	localparam int SEMAPHORES = 32;
	localparam int PROCESSES  = 32;

	// derived widths
	localparam int SEM_IW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int PID_IW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int LEN_W  = $clog2(PROCESSES + 1);
	localparam int NFS_W  = $clog2(SEMAPHORES + 1);
	localparam int MEM_DEPTH = SEMAPHORES * PROCESSES;
	localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_LOCK   = 2'd1;
	localparam logic [1:0] OP_UNLOCK = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [4:0] sem_id;
		logic [4:0] caller_pid;
		logic [7:0] initial_count;
	} req_t;

	typedef struct packed {
		logic [4:0] new_sem_id;
		logic       create_failed;
		logic       caller_blocked;
		logic       released_valid;
		logic [4:0] woken_pid;
	} rsp_t;

	typedef struct packed {
		logic load;   // capture request, start queue read
		logic exec;   // update state, register result
	} cmd_t;

endpackage

>>> rtl/csq_ctrl.sv
module csq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output csq_pkg::cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

endmodule

>>> rtl/csq_dp.sv
module csq_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  csq_pkg::cmd_t   cmd,
	input  csq_pkg::req_t   req,
	output csq_pkg::rsp_t   rsp
);

	logic [7:0]                  count_q [csq_pkg::SEMAPHORES];
	logic [csq_pkg::PID_IW-1:0]  head_q  [csq_pkg::SEMAPHORES];
	logic [csq_pkg::LEN_W-1:0]   len_q   [csq_pkg::SEMAPHORES];
	logic [csq_pkg::NFS_W-1:0]   next_free_q;

	logic [4:0] wq_mem [csq_pkg::MEM_DEPTH];

	csq_pkg::req_t req_q;
	logic [4:0]    rd_q;
	csq_pkg::rsp_t rsp_q;

	// queue head read is addressed from the incoming word
	logic [csq_pkg::SEM_IW-1:0] in_idx;
	logic [csq_pkg::MEM_AW-1:0] rd_addr;

	assign in_idx  = csq_pkg::SEM_IW'(req.sem_id);
	assign rd_addr = csq_pkg::MEM_AW'(csq_pkg::MEM_AW'(in_idx)
		* csq_pkg::MEM_AW'(csq_pkg::PROCESSES))
		+ csq_pkg::MEM_AW'(head_q[in_idx]);

	// execute stage
	logic [csq_pkg::SEM_IW-1:0]  idx;
	logic                        in_range;
	logic [7:0]                  cnt;
	logic [csq_pkg::PID_IW-1:0]  hd;
	logic [csq_pkg::LEN_W-1:0]   ln;
	logic [csq_pkg::PID_IW:0]    tail_sum;
	logic [csq_pkg::PID_IW-1:0]  tail;
	logic [csq_pkg::MEM_AW-1:0]  wr_addr;

	logic                        wr_cnt, wr_ptr, mem_we, bump_free;
	logic [7:0]                  cnt_d;
	logic [csq_pkg::PID_IW-1:0]  hd_d;
	logic [csq_pkg::LEN_W-1:0]   ln_d;
	logic [csq_pkg::SEM_IW-1:0]  upd_idx;
	csq_pkg::rsp_t               rsp_d;

	assign idx      = csq_pkg::SEM_IW'(req_q.sem_id);
	assign in_range = (32'(req_q.sem_id) < csq_pkg::SEMAPHORES);
	assign cnt      = count_q[idx];
	assign hd       = head_q[idx];
	assign ln       = len_q[idx];
	assign tail_sum = {1'b0, hd} + (csq_pkg::PID_IW + 1)'(ln);
	assign tail     = (tail_sum >= (csq_pkg::PID_IW + 1)'(csq_pkg::PROCESSES))
		? csq_pkg::PID_IW'(tail_sum - (csq_pkg::PID_IW + 1)'(csq_pkg::PROCESSES))
		: csq_pkg::PID_IW'(tail_sum);
	assign wr_addr  = csq_pkg::MEM_AW'(csq_pkg::MEM_AW'(idx)
		* csq_pkg::MEM_AW'(csq_pkg::PROCESSES)) + csq_pkg::MEM_AW'(tail);

	always_comb begin
		rsp_d     = '0;
		wr_cnt    = 1'b0;
		wr_ptr    = 1'b0;
		mem_we    = 1'b0;
		bump_free = 1'b0;
		cnt_d     = cnt;
		hd_d      = hd;
		ln_d      = ln;
		upd_idx   = idx;
		case (req_q.opcode)
			csq_pkg::OP_CREATE: begin
				if (32'(next_free_q) < csq_pkg::SEMAPHORES) begin
					upd_idx          = csq_pkg::SEM_IW'(next_free_q);
					rsp_d.new_sem_id = 5'(next_free_q);
					cnt_d            = req_q.initial_count;
					hd_d             = '0;
					ln_d             = '0;
					wr_cnt           = 1'b1;
					wr_ptr           = 1'b1;
					bump_free        = 1'b1;
				end else begin
					rsp_d.create_failed = 1'b1;
				end
			end
			csq_pkg::OP_LOCK: begin
				if (in_range) begin
					if (cnt != 8'd0) begin
						cnt_d  = cnt - 8'd1;
						wr_cnt = 1'b1;
					end else if (ln < csq_pkg::LEN_W'(csq_pkg::PROCESSES)) begin
						ln_d                 = ln + 1'b1;
						wr_ptr               = 1'b1;
						mem_we               = 1'b1;
						rsp_d.caller_blocked = 1'b1;
					end
				end
			end
			csq_pkg::OP_UNLOCK: begin
				if (in_range) begin
					if (ln == '0) begin
						if (cnt != csq_pkg::COUNT_MAX) begin
							cnt_d  = cnt + 8'd1;
							wr_cnt = 1'b1;
						end
					end else begin
						rsp_d.released_valid = 1'b1;
						rsp_d.woken_pid      = rd_q;
						hd_d = (hd == csq_pkg::PID_IW'(csq_pkg::PROCESSES - 1))
							? '0 : csq_pkg::PID_IW'(hd + 1'b1);
						ln_d   = ln - 1'b1;
						wr_ptr = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csq_pkg::SEMAPHORES; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				len_q[i]   <= '0;
			end
			next_free_q <= '0;
		end else if (cmd.exec) begin
			if (wr_cnt)
				count_q[upd_idx] <= cnt_d;
			if (wr_ptr) begin
				head_q[upd_idx] <= hd_d;
				len_q[upd_idx]  <= ln_d;
			end
			if (bump_free)
				next_free_q <= next_free_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			rd_q  <= wq_mem[rd_addr];
		end
		if (cmd.exec)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we)
			wq_mem[wr_addr] <= req_q.caller_pid;
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/counting_semaphore_wait_queue_unit.sv
// A word is taken only in idle; the request and the wait-queue memory read are registered
//   at accept, then the execute state does the read-modify-write of one semaphore's count
//   and queue pointers and registers the result; no new word is taken while busy.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (arst_n low, async): counts, queue heads/lengths and allocation counter clear;
//   the wait-queue memory is not cleared.
module counting_semaphore_wait_queue_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  csq_pkg::req_t   req,
	output logic            done,
	output csq_pkg::rsp_t   rsp
);

	csq_pkg::cmd_t cmd;

	csq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	csq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> rtl/csq_checker.sv
module csq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input csq_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result missing two cycles after accept");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside of item completion");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $countones({rsp.create_failed, rsp.caller_blocked,
			rsp.released_valid}) <= 1)
		else $error("conflicting result flags");

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

>>> test/counting_semaphore_wait_queue_unit_test.sv
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_unit_test;

	typedef struct {
		csq_pkg::req_t word;
		bit            hold;   // wait for every outstanding result before offering this word
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	csq_pkg::req_t req = '0;
	logic busy;
	logic done;
	csq_pkg::rsp_t rsp;

	stim_t         pending_q[$];
	csq_pkg::rsp_t outcome_q[$];

	// semaphore bank as the block should hold it
	logic [7:0]                 sem_count [csq_pkg::SEMAPHORES];
	logic [csq_pkg::PID_IW-1:0] waiter_pid [csq_pkg::SEMAPHORES][csq_pkg::PROCESSES];
	logic [csq_pkg::PID_IW-1:0] wq_head [csq_pkg::SEMAPHORES];
	logic [csq_pkg::LEN_W-1:0]  wq_len [csq_pkg::SEMAPHORES];
	logic [csq_pkg::NFS_W-1:0]  next_free;

	int fail_count = 0;
	int words_sent = 0;
	int results_seen = 0;
	int blocked_seen = 0;
	int released_seen = 0;
	int refused_seen = 0;
	int burst_left = 1;
	int gap_left = 0;

	counting_semaphore_wait_queue_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_bank();
		for (int s = 0; s < csq_pkg::SEMAPHORES; s++) begin
			sem_count[s] = '0;
			wq_head[s] = '0;
			wq_len[s] = '0;
		end
		next_free = '0;
	endtask

	task automatic resolve_semaphore_op(input csq_pkg::req_t w, output csq_pkg::rsp_t r);
		logic [csq_pkg::SEM_IW-1:0] si;
		logic [csq_pkg::SEM_IW-1:0] ni;
		logic [csq_pkg::PID_IW-1:0] slot;
		r = '0;
		si = csq_pkg::SEM_IW'(w.sem_id);
		ni = csq_pkg::SEM_IW'(next_free);
		case (w.opcode)
			csq_pkg::OP_CREATE: begin
				if (32'(next_free) < csq_pkg::SEMAPHORES) begin
					r.new_sem_id = 5'(next_free);
					sem_count[ni] = w.initial_count;
					wq_head[ni] = '0;
					wq_len[ni] = '0;
					next_free = next_free + 1'b1;
				end else begin
					r.create_failed = 1'b1;
				end
			end
			csq_pkg::OP_LOCK: begin
				if (32'(w.sem_id) < csq_pkg::SEMAPHORES) begin
					if (sem_count[si] != 8'd0) begin
						sem_count[si] = sem_count[si] - 8'd1;
					end else if (32'(wq_len[si]) < csq_pkg::PROCESSES) begin
						slot = csq_pkg::PID_IW'((int'(wq_head[si]) + int'(wq_len[si]))
							% csq_pkg::PROCESSES);
						waiter_pid[si][slot] = w.caller_pid;
						wq_len[si] = wq_len[si] + 1'b1;
						r.caller_blocked = 1'b1;
					end
				end
			end
			csq_pkg::OP_UNLOCK: begin
				if (32'(w.sem_id) < csq_pkg::SEMAPHORES) begin
					if (wq_len[si] == '0) begin
						if (sem_count[si] != csq_pkg::COUNT_MAX)
							sem_count[si] = sem_count[si] + 8'd1;
					end else begin
						slot = wq_head[si];
						r.released_valid = 1'b1;
						r.woken_pid = waiter_pid[si][slot];
						wq_head[si] = csq_pkg::PID_IW'((int'(slot) + 1) % csq_pkg::PROCESSES);
						wq_len[si] = wq_len[si] - 1'b1;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_word(input logic [1:0] op, input int sid, input int pid,
			input int init, input bit hold = 1'b0);
		stim_t s;
		s.word.opcode = op;
		s.word.sem_id = sid[4:0];
		s.word.caller_pid = pid[4:0];
		s.word.initial_count = init[7:0];
		s.hold = hold;
		pending_q.push_back(s);
	endtask

	// sender: bursts of words separated by random gaps
	always @(posedge clk) begin : drive
		csq_pkg::rsp_t outcome;
		stim_t         item;
		logic          holding;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			holding = start && busy;
			if (start && !busy) begin
				resolve_semaphore_op(req, outcome);
				outcome_q.push_back(outcome);
				words_sent++;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_q.size() != 0 &&
						!(pending_q[0].hold && outcome_q.size() != 0)) begin
					item = pending_q.pop_front();
					req <= item.word;
					start <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// results are strobed for one cycle; take each at the edge ending its cycle
	always @(posedge clk) begin : observe
		csq_pkg::rsp_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (outcome_q.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = outcome_q.pop_front();
				if (rsp.new_sem_id !== want.new_sem_id)
					report_mismatch($sformatf("new_sem_id %0d, want %0d",
						rsp.new_sem_id, want.new_sem_id));
				if (rsp.create_failed !== want.create_failed)
					report_mismatch($sformatf("create_failed %b, want %b",
						rsp.create_failed, want.create_failed));
				if (rsp.caller_blocked !== want.caller_blocked)
					report_mismatch($sformatf("caller_blocked %b, want %b",
						rsp.caller_blocked, want.caller_blocked));
				if (rsp.released_valid !== want.released_valid)
					report_mismatch($sformatf("released_valid %b, want %b",
						rsp.released_valid, want.released_valid));
				if (rsp.woken_pid !== want.woken_pid)
					report_mismatch($sformatf("woken_pid %0d, want %0d",
						rsp.woken_pid, want.woken_pid));
				blocked_seen += want.caller_blocked;
				released_seen += want.released_valid;
				refused_seen += want.create_failed;
			end
		end
	end

	initial begin : watchdog
		#400000;
		$display("counting_semaphore_wait_queue_unit regression: fail");
		$finish;
	end

	initial begin : main
		int rand_items;
		int sid;
		int n;
		int pick;
		int init;
		clear_bank();

		// directed: no-ops, untouched semaphore, saturation, FIFO order
		queue_word(csq_pkg::OP_NOP, 31, 31, 255);
		queue_word(csq_pkg::OP_NOP, 0, 0, 0);
		queue_word(csq_pkg::OP_LOCK, 31, 31, 0);
		queue_word(csq_pkg::OP_UNLOCK, 31, 0, 255);
		queue_word(csq_pkg::OP_UNLOCK, 31, 5, 0);
		queue_word(csq_pkg::OP_LOCK, 31, 0, 0);
		queue_word(csq_pkg::OP_CREATE, 0, 0, 255);
		queue_word(csq_pkg::OP_UNLOCK, 0, 0, 0);
		queue_word(csq_pkg::OP_LOCK, 0, 31, 0);
		queue_word(csq_pkg::OP_CREATE, 31, 31, 0);
		queue_word(csq_pkg::OP_LOCK, 1, 0, 255);
		queue_word(csq_pkg::OP_LOCK, 1, 17, 0);
		queue_word(csq_pkg::OP_LOCK, 1, 10, 0);
		queue_word(csq_pkg::OP_UNLOCK, 1, 31, 0);
		queue_word(csq_pkg::OP_UNLOCK, 1, 0, 0);
		queue_word(csq_pkg::OP_UNLOCK, 1, 0, 0);
		queue_word(csq_pkg::OP_UNLOCK, 1, 0, 0);
		queue_word(csq_pkg::OP_CREATE, 16, 21, 128);
		queue_word(csq_pkg::OP_LOCK, 2, 3, 0);
		queue_word(csq_pkg::OP_UNLOCK, 2, 3, 0);
		queue_word(csq_pkg::OP_CREATE, 0, 0, 1);
		queue_word(csq_pkg::OP_LOCK, 3, 9, 0);
		queue_word(csq_pkg::OP_LOCK, 3, 12, 0, 1'b1);

		// overfill one wait queue on an uncreated semaphore, then drain it past empty
		rand_items = 0;
		for (int i = 0; i < csq_pkg::PROCESSES + 2; i++) begin
			queue_word(csq_pkg::OP_LOCK, 29, $urandom_range(0, 31), $urandom_range(0, 255));
			rand_items++;
		end
		for (int i = 0; i < csq_pkg::PROCESSES + 2; i++) begin
			queue_word(csq_pkg::OP_UNLOCK, 29, $urandom_range(0, 31),
				$urandom_range(0, 255), i == 0);
			rand_items++;
		end

		while (rand_items < 400) begin
			pick = $urandom_range(0, 9);
			sid = $urandom_range(0, 31);
			if (pick <= 4) begin
				n = $urandom_range(0, 19);
				init = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
				if (n < 4)
					queue_word(csq_pkg::OP_CREATE, sid, $urandom_range(0, 31), init);
				else if (n < 11)
					queue_word(csq_pkg::OP_LOCK, sid, $urandom_range(0, 31), init);
				else if (n < 18)
					queue_word(csq_pkg::OP_UNLOCK, sid, $urandom_range(0, 31), init);
				else
					queue_word(csq_pkg::OP_NOP, sid, $urandom_range(0, 31), init);
				rand_items++;
			end else if (pick <= 6) begin
				n = $urandom_range(4, csq_pkg::PROCESSES + 4);
				for (int i = 0; i < n; i++)
					queue_word(csq_pkg::OP_LOCK, sid, $urandom_range(0, 31),
						$urandom_range(0, 255));
				rand_items += n;
			end else if (pick <= 8) begin
				n = $urandom_range(2, csq_pkg::PROCESSES + 4);
				for (int i = 0; i < n; i++)
					queue_word(csq_pkg::OP_UNLOCK, sid, $urandom_range(0, 31),
						$urandom_range(0, 255));
				rand_items += n;
			end else begin
				queue_word(2'($urandom_range(0, 3)), sid, $urandom_range(0, 31),
					$urandom_range(0, 255), 1'b1);
				rand_items++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start || outcome_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("sent %0d words, checked %0d results", words_sent, results_seen);
		$display("callers suspended %0d, waiters released %0d, creates refused %0d",
			blocked_seen, released_seen, refused_seen);
		if (fail_count == 0)
			$display("counting_semaphore_wait_queue_unit regression: pass");
		else
			$display("counting_semaphore_wait_queue_unit regression: fail");
		$finish;
	end

endmodule
